// ----- src/hmq_pkg.sv -----
// Shared types and constants for the binary max-heap queue.
// Request and response payload structs, function and status codes.
// No dependencies.
package hmq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int FUNC_W       = 2;
  localparam int SLOT_W       = 6;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;

  // request functions
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd2;

  // response status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic [SLOT_W-1:0]       slot;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count_after;
    logic signed [KEY_W-1:0] top_key;
  } rsp_t;

endpackage

// ----- src/hmq_mem.sv -----
// Heap key storage: one write port, one read port, registered read data.
// Depends on hmq_pkg for the key width.
module hmq_mem #(
  parameter int DEPTH = hmq_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [hmq_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [hmq_pkg::KEY_W-1:0] rdata
);

  logic [hmq_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hmq_ctrl.sv -----
// Heap sequencer: entry count, sift-up / raise / sift-down walks over
// the key memory, one memory read per step. Depends on hmq_pkg.
module hmq_ctrl #(
  parameter int CAPACITY = hmq_pkg::CAPACITY_DEF,
  parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  hmq_pkg::req_t             req,
  output logic                      busy,
  output logic                      rsp_valid,
  output hmq_pkg::rsp_t             rsp,
  output logic                      mem_we,
  output logic [IW-1:0]             mem_waddr,
  output logic [hmq_pkg::KEY_W-1:0] mem_wdata,
  output logic [IW-1:0]             mem_raddr,
  input  logic [hmq_pkg::KEY_W-1:0] mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;                       // holds 2*i+2
  localparam int MW = (XW > hmq_pkg::SLOT_W) ? XW : hmq_pkg::SLOT_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CHK   = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_RM_RD    = 4'd3;
  localparam logic [3:0] S_RM_GET   = 4'd4;
  localparam logic [3:0] S_RAISE    = 4'd5;
  localparam logic [3:0] S_RAISE_W  = 4'd6;
  localparam logic [3:0] S_LAST     = 4'd7;
  localparam logic [3:0] S_LAST_GET = 4'd8;
  localparam logic [3:0] S_DN_L     = 4'd9;
  localparam logic [3:0] S_DN_R     = 4'd10;
  localparam logic [3:0] S_DN_C     = 4'd11;
  localparam logic [3:0] S_TOP      = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]                       state_r, state_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic signed [hmq_pkg::KEY_W-1:0] val_r, val_nxt;     // key riding the hole
  logic signed [hmq_pkg::KEY_W-1:0] rem_r, rem_nxt;
  logic signed [hmq_pkg::KEY_W-1:0] cand_r, cand_nxt;   // larger of key, left child
  logic                             cand_l_r, cand_l_nxt;
  logic [hmq_pkg::STATUS_W-1:0]     stat_r, stat_nxt;

  logic [IW-1:0]                    parent;
  logic [XW-1:0]                    lchild, rchild, cnt_x;
  logic signed [hmq_pkg::KEY_W-1:0] rd_s;
  logic                             take_l, take_r;
  logic [MW-1:0]                    slot_m, cnt_m;

  assign parent = (idx_r - IW'(1)) >> 1;
  assign lchild = {1'b0, idx_r, 1'b1};
  assign rchild = lchild + XW'(1);
  assign cnt_x  = XW'(cnt_r);
  assign rd_s   = $signed(mem_rdata);
  assign take_l = rd_s > val_r;
  assign take_r = rd_s > cand_r;
  assign slot_m = MW'(req.slot);
  assign cnt_m  = MW'(cnt_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    rem_nxt    = rem_r;
    cand_nxt   = cand_r;
    cand_l_nxt = cand_l_r;
    stat_nxt   = stat_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = val_r;
    mem_raddr  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          rem_nxt   = '0;
          stat_nxt  = hmq_pkg::ST_OK;
          state_nxt = S_TOP;
          case (req.func)
            hmq_pkg::FUNC_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                stat_nxt = hmq_pkg::ST_FULL;
              end else begin
                idx_nxt   = IW'(cnt_r);
                val_nxt   = req.key;
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_CHK;
              end
            end
            hmq_pkg::FUNC_EXTRACT: begin
              if (cnt_r == '0) begin
                stat_nxt = hmq_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_RM_RD;
              end
            end
            hmq_pkg::FUNC_REMOVE: begin
              if (cnt_r == '0) begin
                stat_nxt = hmq_pkg::ST_EMPTY;
              end else if (slot_m >= cnt_m) begin
                stat_nxt = hmq_pkg::ST_INDEX;
              end else begin
                idx_nxt   = IW'(req.slot);
                state_nxt = S_RM_RD;
              end
            end
            default: begin
              state_nxt = S_TOP;
            end
          endcase
        end
      end
      // sift-up: parent moves down into the hole while strictly smaller
      S_UP_CHK: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_TOP;
        end else begin
          mem_raddr = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_s < val_r) begin
          mem_wdata = rd_s;
          idx_nxt   = parent;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_RM_RD: begin
        mem_raddr = idx_r;
        state_nxt = S_RM_GET;
      end
      S_RM_GET: begin
        rem_nxt   = rd_s;
        state_nxt = S_RAISE;
      end
      // unconditional raise: every ancestor shifts down one level
      S_RAISE: begin
        if (idx_r == '0) begin
          state_nxt = S_LAST;
        end else begin
          mem_raddr = parent;
          state_nxt = S_RAISE_W;
        end
      end
      S_RAISE_W: begin
        mem_we    = 1'b1;
        mem_wdata = rd_s;
        idx_nxt   = parent;
        state_nxt = S_RAISE;
      end
      S_LAST: begin
        cnt_nxt   = cnt_r - CW'(1);
        mem_raddr = IW'(cnt_r - CW'(1));
        state_nxt = S_LAST_GET;
      end
      S_LAST_GET: begin
        val_nxt   = rd_s;
        idx_nxt   = '0;
        state_nxt = S_DN_L;
      end
      // sift-down: left child first, right only if strictly above the pick
      S_DN_L: begin
        if (lchild < cnt_x) begin
          mem_raddr = IW'(lchild);
          state_nxt = S_DN_R;
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_TOP;
        end
      end
      S_DN_R: begin
        cand_nxt   = take_l ? rd_s : val_r;
        cand_l_nxt = take_l;
        if (rchild < cnt_x) begin
          mem_raddr = IW'(rchild);
          state_nxt = S_DN_C;
        end else if (take_l) begin
          mem_we    = 1'b1;
          mem_wdata = rd_s;
          idx_nxt   = IW'(lchild);
          state_nxt = S_DN_L;
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_TOP;
        end
      end
      S_DN_C: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = rd_s;
          idx_nxt   = IW'(rchild);
          state_nxt = S_DN_L;
        end else if (cand_l_r) begin
          mem_wdata = cand_r;
          idx_nxt   = IW'(lchild);
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        mem_raddr = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    rem_r    <= rem_nxt;
    cand_r   <= cand_nxt;
    cand_l_r <= cand_l_nxt;
    stat_r   <= stat_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign rsp_valid = (state_r == S_DONE);

  always_comb begin
    rsp.removed_key = rem_r;
    rsp.status      = stat_r;
    rsp.count_after = hmq_pkg::COUNT_W'(cnt_r);
    rsp.top_key     = (cnt_r == '0) ? '0 : rd_s;
  end

endmodule

// ----- src/binary_max_heap_queue.sv -----
// Top level of the binary max-heap priority queue of signed 32-bit keys.
// Instantiates hmq_ctrl (sequencer) and hmq_mem (key storage); uses hmq_pkg.
//
// One request at a time: a request is taken when start is high and busy is
// low. Its response appears on out_data for exactly one cycle with out_valid
// high and must be captured then, since the receiver cannot stall it. busy
// drops the cycle after the response, which is the earliest the next
// request can be taken. Each request walks the single-read-port key memory
// one tree level per step:
//   - insert places the key at the end and climbs it while the parent is
//     strictly smaller;
//   - extract moves the last entry to the root and sinks it;
//   - remove first shifts every ancestor of the chosen slot down one level,
//     then finishes as an extract.
// Full, empty, bad-index and no-op requests answer without a walk and
// leave the heap untouched. No clearing pass after reset: only entries
// below the count are ever used.
module binary_max_heap_queue #(
  parameter int CAPACITY = hmq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hmq_pkg::req_t in_data,
  output logic          out_valid,
  output hmq_pkg::rsp_t out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic [hmq_pkg::KEY_W-1:0] mem_wdata;
  logic [IW-1:0]             mem_raddr;
  logic [hmq_pkg::KEY_W-1:0] mem_rdata;

  // sequencer: owns the count and walks the heap
  hmq_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_data),
    .busy      (busy),
    .rsp_valid (out_valid),
    .rsp       (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // key storage, registered read data
  hmq_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // an accepted request always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted request did not set busy");

  // response strobe is a single cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("response strobe longer than one cycle");

  // heap memory is only written while a request is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> busy && !out_valid) else $error("memory write outside a request");

  // an empty heap reports a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.count_after == '0) |-> (out_data.top_key == '0))
    else $error("nonzero top on empty heap");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for binary_max_heap_queue: directed and random
// insert / extract / remove requests checked against a behavioral heap.
// Depends on hmq_pkg (payload structs, codes) and the RTL under src/.
module testbench;
  import hmq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no request or response taken
  localparam int TAIL_CYCLES = 40;    // longer than the slowest remove
  localparam int RANDOM_REQS = 750;

  // unused selector: block reports state and does nothing
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_data = '0;
  logic busy;
  logic out_valid;
  rsp_t out_data;

  binary_max_heap_queue #(.CAPACITY(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow heap: predicts each response at the edge its request is taken.
  // ---------------------------------------------------------------------
  logic signed [KEY_W-1:0] shadow_heap [DEPTH];
  int shadow_count = 0;
  int peak_count   = 0;

  function automatic void swap_entries(int a, int b);
    logic signed [KEY_W-1:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  // climb while the parent is strictly smaller; forced climbs to the root
  function automatic void float_up(int idx, bit forced);
    int parent;
    while (idx > 0) begin
      parent = (idx - 1) / 2;
      if (!forced && !(shadow_heap[parent] < shadow_heap[idx]))
        return;
      swap_entries(parent, idx);
      idx = parent;
    end
  endfunction

  // left child wins ties against the right one: right must be strictly larger
  function automatic void sink_down(int idx);
    int pick;
    int lc;
    int rc;
    while (1'b1) begin
      pick = idx;
      lc = 2 * idx + 1;
      rc = 2 * idx + 2;
      if (lc < shadow_count && shadow_heap[lc] > shadow_heap[pick]) pick = lc;
      if (rc < shadow_count && shadow_heap[rc] > shadow_heap[pick]) pick = rc;
      if (pick == idx)
        return;
      swap_entries(idx, pick);
      idx = pick;
    end
  endfunction

  function automatic logic signed [KEY_W-1:0] pop_root();
    logic signed [KEY_W-1:0] root;
    root = shadow_heap[0];
    shadow_count--;
    shadow_heap[0] = shadow_heap[shadow_count];
    sink_down(0);
    return root;
  endfunction

  function automatic rsp_t predict_response(req_t rq);
    rsp_t rs;
    rs = '0;
    rs.status = ST_OK;
    case (rq.func)
      FUNC_INSERT: begin
        if (shadow_count >= DEPTH) begin
          rs.status = ST_FULL;
        end else begin
          shadow_heap[shadow_count] = rq.key;
          shadow_count++;
          float_up(shadow_count - 1, 1'b0);
        end
      end
      FUNC_EXTRACT: begin
        if (shadow_count == 0) rs.status = ST_EMPTY;
        else rs.removed_key = pop_root();
      end
      FUNC_REMOVE: begin
        if (shadow_count == 0) begin
          rs.status = ST_EMPTY;
        end else if (int'(rq.slot) >= shadow_count) begin
          rs.status = ST_INDEX;
        end else begin
          // entry treated as above every key: pulled to the root, then popped
          rs.removed_key = shadow_heap[rq.slot];
          float_up(int'(rq.slot), 1'b1);
          void'(pop_root());
        end
      end
      default: ;
    endcase
    rs.count_after = COUNT_W'(shadow_count);
    rs.top_key = (shadow_count > 0) ? shadow_heap[0] : '0;
    if (shadow_count > peak_count) peak_count = shadow_count;
    return rs;
  endfunction

  // ---------------------------------------------------------------------
  // Request list, built up front. gen_count mirrors occupancy only, to
  // steer fill / drain phases and pick mostly legal slots.
  // ---------------------------------------------------------------------
  req_t req_q[$];
  int   gap_q[$];     // idle cycles after each request
  int   gen_count = 0;

  function automatic int rand_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0, 1: return KEY_W'(int'($urandom_range(0, 16)) - 8);  // many duplicates
      2: return KEY_MAX;
      3: return KEY_MIN;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [FUNC_W-1:0] fn, logic signed [KEY_W-1:0] k, int s,
                         bit quiet);
    req_t rq;
    rq.func = fn;
    rq.key  = k;
    rq.slot = SLOT_W'(s);
    req_q.push_back(rq);
    gap_q.push_back(rand_gap(quiet));
    case (fn)
      FUNC_INSERT:  if (gen_count < DEPTH) gen_count++;
      FUNC_EXTRACT: if (gen_count > 0) gen_count--;
      FUNC_REMOVE:  if (gen_count > 0 && s < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: start held until the request is taken (start && !busy).
  // ---------------------------------------------------------------------
  rsp_t pending_q[$];
  int   gap_left = 0;
  int   accepted_cnt = 0;
  int   func_seen[4] = '{default: 0};

  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        pending_q.push_back(predict_response(in_data));
        accepted_cnt++;
        func_seen[in_data.func]++;
      end
      // one assignment to start per edge: stays high if next request is ready
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_q.size() > 0) begin
          start    <= 1'b1;
          in_data  <= req_q.pop_front();
          gap_left <= gap_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed response must match the oldest prediction.
  // ---------------------------------------------------------------------
  int error_cnt   = 0;
  int checked_cnt = 0;
  int status_seen[4] = '{default: 0};

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_q.size() == 0) begin
        $display("%0t: response with no request outstanding: expected none, actual %p",
                 $time, out_data);
        error_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("removed_key", want.removed_key, out_data.removed_key);
        check_field("status",      want.status,      out_data.status);
        check_field("count_after", want.count_after, out_data.count_after);
        check_field("top_key",     want.top_key,     out_data.top_key);
        status_seen[want.status]++;
        checked_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: cycles in which neither a request nor a response is taken.
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: timeout, nothing taken for %0d cycles (%0d responses outstanding)",
             $time, IDLE_LIMIT, pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int total;
    int mode;
    int len;
    int r;
    int s;
    bit quiet;

    // directed: empty heap, key extremes, equal keys, bad slots, every removal path
    add_req(FUNC_EXTRACT, KEY_W'($urandom), 0, 1'b1);   // extract on empty
    add_req(FUNC_REMOVE,  KEY_W'($urandom), 0, 1'b0);   // remove on empty
    add_req(FUNC_NOP,     KEY_W'($urandom), 63, 1'b0);  // unused selector, empty
    add_req(FUNC_INSERT,  KEY_MAX, 0, 1'b1);
    add_req(FUNC_INSERT,  KEY_MIN, 63, 1'b1);
    add_req(FUNC_INSERT,  '0, 0, 1'b0);
    add_req(FUNC_INSERT,  -1, 0, 1'b0);
    add_req(FUNC_INSERT,  KEY_MAX, 0, 1'b0);            // climbs, then stops below the equal root
    add_req(FUNC_REMOVE,  KEY_W'($urandom), 63, 1'b0);  // slot far past count
    add_req(FUNC_REMOVE,  KEY_W'($urandom), 5, 1'b0);   // slot equal to count
    add_req(FUNC_NOP,     KEY_W'($urandom), 2, 1'b1);
    add_req(FUNC_REMOVE,  KEY_W'($urandom), 4, 1'b0);   // last entry
    add_req(FUNC_REMOVE,  KEY_W'($urandom), 1, 1'b0);   // inner entry
    add_req(FUNC_REMOVE,  KEY_W'($urandom), 0, 1'b1);   // root
    add_req(FUNC_EXTRACT, KEY_W'($urandom), 0, 1'b0);
    add_req(FUNC_INSERT,  1, 0, 1'b1);
    add_req(FUNC_INSERT,  1, 0, 1'b1);
    add_req(FUNC_INSERT,  2, 0, 1'b0);
    for (int i = 0; i < 5; i++)
      add_req(FUNC_EXTRACT, KEY_W'($urandom), 0, i[0]);  // last one hits empty

    // random: phases biased to fill, drain or mix, first two fill then drain
    // so full and empty heaps are reached early
    for (int ph = 0; req_q.size() < 23 + RANDOM_REQS; ph++) begin
      mode  = (ph < 2) ? ph : $urandom_range(0, 2);
      len   = (ph < 2) ? 110 : $urandom_range(30, 120);
      quiet = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < len && req_q.size() < 23 + RANDOM_REQS; j++) begin
        r = $urandom_range(0, 99);
        s = (gen_count > 0 && $urandom_range(0, 9) != 0) ?
            $urandom_range(0, gen_count - 1) : $urandom_range(0, DEPTH - 1);
        if (r >= 97)
          add_req(FUNC_NOP, rand_key(), s, quiet);
        else if (r < (mode == 0 ? 80 : mode == 1 ? 15 : 45))
          add_req(FUNC_INSERT, rand_key(), s, quiet);
        else if (r < (mode == 0 ? 88 : mode == 1 ? 55 : 70))
          add_req(FUNC_EXTRACT, KEY_W'($urandom), s, quiet);
        else
          add_req(FUNC_REMOVE, KEY_W'($urandom), s, quiet);
      end
    end
    total = req_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total || checked_cnt < accepted_cnt) @(posedge clk);
    // let any stray response show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d inserts, %0d extracts, %0d removes, %0d no-ops; "
             , accepted_cnt, func_seen[FUNC_INSERT], func_seen[FUNC_EXTRACT],
             func_seen[FUNC_REMOVE], func_seen[FUNC_NOP]);
    $display("peak occupancy %0d of %0d; status ok %0d, full %0d, empty %0d, index %0d",
             peak_count, DEPTH, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_INDEX]);
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hmq_pkg.sv
src/hmq_mem.sv
src/hmq_ctrl.sv
src/binary_max_heap_queue.sv
tb/testbench.sv
